// ===== rtl/sofh_pkg.sv =====
// Shared types and constants for the start/length/end frame hunter.
package sofh_pkg;

	localparam int DATA_W = 8;
	localparam int LEN_W = 7;
	localparam int TOT_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned LEN_LO_OFF = 2;
	localparam int unsigned LEN_HI_OFF = 3;
	localparam int unsigned FRAME_OVERHEAD = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

	localparam logic [DATA_W-1:0] START_BYTE_RST = 8'd0;
	localparam logic [DATA_W-1:0] END_BYTE_RST = 8'd255;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;

	typedef struct packed {
		logic [DATA_W-1:0] start_byte;
		logic [DATA_W-1:0] end_byte;
		logic [LEN_W-1:0]  max_frame_len;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] frame_byte;
		logic [LEN_W-1:0]  frame_length;
		logic              last_of_frame;
	} out_req_t;

endpackage

// ===== rtl/sofh_if.sv =====
// Valid/ready channel interfaces for received bytes and emitted frame bytes.
interface sofh_rx_if;
	logic                      valid;
	logic                      ready;
	logic [sofh_pkg::DATA_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sofh_frame_if;
	logic                      valid;
	logic                      ready;
	logic [sofh_pkg::DATA_W-1:0] frame_byte;
	logic [sofh_pkg::LEN_W-1:0]  frame_length;
	logic                      last_of_frame;

	modport source (output valid, output frame_byte, output frame_length,
		output last_of_frame, input ready);
	modport sink (input valid, input frame_byte, input frame_length,
		input last_of_frame, output ready);
endinterface

// ===== rtl/sof_len_eof_frame_hunter_unit.sv =====
// Top level: config registers, byte ring RAM, hunt sequencer and output register.
// Each byte enters the ring, then a hunt step returns to IDLE when under 4 bytes are held.
// Head bytes are discarded one by one, each checked through the single RAM read port.
// A complete frame passes HUNT, CHK0, RD2, RD3, CHKT and CHKE once its end byte is accepted,
// then streams 1 byte per cycle unless the output stalls; no new byte is taken until the frame is handed off.
// Reset clears control and config registers at once; ring contents are not cleared.
module sof_len_eof_frame_hunter_unit #(
	parameter int RING_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sofh_rx_if.sink                           rx,
	sofh_frame_if.source                      frame,
	input  logic                              cfg_we,
	input  logic [sofh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sofh_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(RING_DEPTH);

	sofh_pkg::cfg_t      cfg_q;
	sofh_pkg::out_req_t  out_req;
	logic                out_space;
	logic                out_valid_q;
	logic [sofh_pkg::DATA_W-1:0] out_byte_q;
	logic [sofh_pkg::LEN_W-1:0]  out_len_q;
	logic                out_last_q;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	logic [sofh_pkg::DATA_W-1:0] mem_wdata;
	logic [IDX_W-1:0]        mem_raddr;
	logic [sofh_pkg::DATA_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= sofh_pkg::START_BYTE_RST;
			cfg_q.end_byte <= sofh_pkg::END_BYTE_RST;
			cfg_q.max_frame_len <= sofh_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sofh_pkg::CFG_START_BYTE: cfg_q.start_byte <= cfg_data;
				sofh_pkg::CFG_END_BYTE:   cfg_q.end_byte <= cfg_data;
				sofh_pkg::CFG_MAX_LEN:    cfg_q.max_frame_len <= cfg_data[sofh_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	sofh_ram #(
		.WIDTH (sofh_pkg::DATA_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sofh_ctrl #(
		.RING_DEPTH (RING_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.rx_byte),
		.out_req   (out_req),
		.out_space (out_space),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// output register: takes a new byte when empty or being drained
	assign out_space = !out_valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_space) begin
			out_valid_q <= out_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_space && out_req.valid) begin
			out_byte_q <= out_req.frame_byte;
			out_len_q <= out_req.frame_length;
			out_last_q <= out_req.last_of_frame;
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.frame_length = out_len_q;
	assign frame.last_of_frame = out_last_q;

endmodule

// ===== rtl/sofh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sofh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sofh_ctrl.sv =====
// Ring bookkeeping and frame hunt sequencer working through the byte RAM.
module sofh_ctrl #(
	parameter int RING_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sofh_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sofh_pkg::DATA_W-1:0]   in_byte,
	output sofh_pkg::out_req_t            out_req,
	input  logic                          out_space,
	output logic                          mem_we,
	output logic [$clog2(RING_DEPTH)-1:0] mem_waddr,
	output logic [sofh_pkg::DATA_W-1:0]   mem_wdata,
	output logic [$clog2(RING_DEPTH)-1:0] mem_raddr,
	input  logic [sofh_pkg::DATA_W-1:0]   mem_rdata
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RING_DEPTH);
	localparam logic [sofh_pkg::LEN_W-1:0] DEPTH_L = sofh_pkg::LEN_W'(RING_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HUNT = 3'd1;
	localparam logic [2:0] ST_CHK0 = 3'd2;
	localparam logic [2:0] ST_RD2  = 3'd3;
	localparam logic [2:0] ST_RD3  = 3'd4;
	localparam logic [2:0] ST_CHKT = 3'd5;
	localparam logic [2:0] ST_CHKE = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0]                   state_q;
	logic [IDX_W-1:0]             head_q;
	logic [FILL_W-1:0]            fill_q;
	logic [sofh_pkg::DATA_W-1:0]  lo_q;
	logic [sofh_pkg::TOT_W-1:0]   total_q;
	logic [FILL_W-1:0]            k_q;

	logic [sofh_pkg::LEN_W-1:0]   limit;
	logic                         tot_big;
	logic [FILL_W-1:0]            tot_f;
	logic [FILL_W-1:0]            rd_off;
	logic                         take;
	logic                         last_k;

	// ring position base + off, with off <= depth so one subtract wraps it
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
		input logic [FILL_W-1:0] off);
		logic [FILL_W:0] s;
		s = (FILL_W+1)'(base) + (FILL_W+1)'(off);
		if (s >= (FILL_W+1)'(RING_DEPTH)) begin
			s = s - (FILL_W+1)'(RING_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	assign limit = (cfg.max_frame_len > DEPTH_L) ? DEPTH_L : cfg.max_frame_len;
	assign tot_big = total_q > sofh_pkg::TOT_W'(limit);
	assign tot_f = total_q[FILL_W-1:0];
	assign take = (state_q == ST_EMIT) && out_space;
	assign last_k = (k_q == tot_f - 1'b1);

	assign in_ready = (state_q == ST_IDLE);
	assign mem_we = in_valid && in_ready && (fill_q != DEPTH_F);
	assign mem_waddr = wrap_add(head_q, fill_q);
	assign mem_wdata = in_byte;

	// read address is issued in the state ahead of the one that uses the data
	always_comb begin
		rd_off = '0;
		case (state_q)
			ST_CHK0: rd_off = FILL_W'(sofh_pkg::LEN_LO_OFF);
			ST_RD2:  rd_off = FILL_W'(sofh_pkg::LEN_HI_OFF);
			ST_CHKT: rd_off = tot_big ? '0 : tot_f - 1'b1;
			ST_EMIT: rd_off = take ? k_q + 1'b1 : k_q;
			default: rd_off = '0;
		endcase
	end

	assign mem_raddr = wrap_add(head_q, rd_off);

	assign out_req.valid = (state_q == ST_EMIT);
	assign out_req.frame_byte = mem_rdata;
	assign out_req.frame_length = sofh_pkg::LEN_W'(tot_f);
	assign out_req.last_of_frame = last_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			fill_q <= '0;
			lo_q <= '0;
			total_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (fill_q != DEPTH_F) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_HUNT;
					end
				end
				ST_HUNT: begin
					if (fill_q < FILL_W'(sofh_pkg::HDR_BYTES)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHK0;
					end
				end
				ST_CHK0: begin
					if (mem_rdata != cfg.start_byte) begin
						head_q <= wrap_add(head_q, FILL_W'(1));
						fill_q <= fill_q - 1'b1;
						state_q <= ST_HUNT;
					end else begin
						state_q <= ST_RD2;
					end
				end
				ST_RD2: begin
					lo_q <= mem_rdata;
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					total_q <= sofh_pkg::TOT_W'({mem_rdata, lo_q}) +
						sofh_pkg::TOT_W'(sofh_pkg::FRAME_OVERHEAD);
					state_q <= ST_CHKT;
				end
				ST_CHKT: begin
					if (tot_big) begin
						head_q <= wrap_add(head_q, FILL_W'(1));
						fill_q <= fill_q - 1'b1;
						state_q <= ST_HUNT;
					end else if (fill_q < tot_f) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHKE;
					end
				end
				ST_CHKE: begin
					if (mem_rdata != cfg.end_byte) begin
						head_q <= wrap_add(head_q, FILL_W'(1));
						fill_q <= fill_q - 1'b1;
						state_q <= ST_HUNT;
					end else begin
						k_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (take) begin
						if (last_k) begin
							head_q <= wrap_add(head_q, tot_f);
							fill_q <= fill_q - tot_f;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/sofh_checker.sv =====
// Port-level checks for the frame hunter, bound to the top level.
module sofh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rx_valid,
	input logic                          rx_ready,
	input logic                          frame_valid,
	input logic                          frame_ready,
	input logic [sofh_pkg::DATA_W-1:0]   frame_byte,
	input logic [sofh_pkg::LEN_W-1:0]    frame_length,
	input logic                          last_of_frame
);

	logic                        out_acc;
	logic                        in_frame_q;
	logic [sofh_pkg::LEN_W-1:0]  len_q;
	logic [sofh_pkg::LEN_W-1:0]  cnt_q;

	assign out_acc = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			len_q <= '0;
			cnt_q <= '0;
		end else if (out_acc) begin
			if (last_of_frame) begin
				in_frame_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				in_frame_q <= 1'b1;
				len_q <= frame_length;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte) &&
		$stable(frame_length) && $stable(last_of_frame))
		else $error("frame request changed while stalled");

	a_len_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && in_frame_q |-> frame_length == len_q)
		else $error("frame length changed inside a frame");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> last_of_frame == (cnt_q + 1'b1 == frame_length))
		else $error("last flag not on byte number frame_length");

	a_rx_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready |=> !rx_ready)
		else $error("byte taken without a hunt cycle");

endmodule

bind sof_len_eof_frame_hunter_unit sofh_checker u_sofh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.frame_valid   (frame.valid),
	.frame_ready   (frame.ready),
	.frame_byte    (frame.frame_byte),
	.frame_length  (frame.frame_length),
	.last_of_frame (frame.last_of_frame)
);

// ===== bench/sofh_frame_checker.sv =====
// Frame hunter checker: watches both channels and the register port, predicts and compares.
module sofh_frame_checker #(
	parameter int RING_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rx_valid,
	input  logic                            rx_ready,
	input  logic [sofh_pkg::DATA_W-1:0]     rx_byte,
	input  logic                            frame_valid,
	input  logic                            frame_ready,
	input  logic [sofh_pkg::DATA_W-1:0]     frame_byte,
	input  logic [sofh_pkg::LEN_W-1:0]      frame_length,
	input  logic                            last_of_frame,
	input  logic                            cfg_we,
	input  logic [sofh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sofh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_count,
	output int                              bytes_due
);
	import sofh_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  length;
		logic              last;
	} frame_beat_t;

	cfg_t              regs_shadow;
	logic [DATA_W-1:0] ring [RING_DEPTH];
	int unsigned       head;
	int unsigned       held;
	frame_beat_t       due_beats [$];
	int                mismatches = 0;
	int                due_count = 0;

	assign mismatch_count = mismatches;
	assign bytes_due = due_count;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("frame check: %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
		mismatches++;
	endtask

	function automatic logic [DATA_W-1:0] ring_at(input int unsigned off);
		return ring[(head + off) % RING_DEPTH];
	endfunction

	function automatic void drop_head();
		if (held > 0) begin
			head = (head + 1) % RING_DEPTH;
			held--;
		end
	endfunction

	// Store one received byte, then hunt; emits at most one frame per byte.
	task automatic hunt_byte(input logic [DATA_W-1:0] b);
		int unsigned cap;
		int unsigned total;
		int unsigned k;
		bit          stop;
		frame_beat_t beat;
		cap = (regs_shadow.max_frame_len > RING_DEPTH) ? RING_DEPTH : regs_shadow.max_frame_len;
		if (held < RING_DEPTH) begin
			ring[(head + held) % RING_DEPTH] = b;
			held++;
		end
		stop = 1'b0;
		while (!stop && held >= HDR_BYTES) begin
			if (ring_at(0) != regs_shadow.start_byte) begin
				drop_head();
			end else begin
				total = int'({ring_at(LEN_HI_OFF), ring_at(LEN_LO_OFF)}) + FRAME_OVERHEAD;
				if (total > cap) begin
					drop_head();
				end else if (held < total) begin
					stop = 1'b1;
				end else if (ring_at(total - 1) != regs_shadow.end_byte) begin
					drop_head();
				end else begin
					for (k = 0; k < total; k++) begin
						beat.data = ring_at(k);
						beat.length = LEN_W'(total);
						beat.last = (k + 1 == total);
						due_beats.push_back(beat);
					end
					head = (head + total) % RING_DEPTH;
					held -= total;
					stop = 1'b1;
				end
			end
		end
	endtask

	task automatic check_beat();
		frame_beat_t want;
		if (due_beats.size() == 0) begin
			report("frame byte with nothing due", frame_byte, 0);
		end else begin
			want = due_beats.pop_front();
			if (frame_byte !== want.data)
				report("frame_byte", frame_byte, want.data);
			if (frame_length !== want.length)
				report("frame_length", frame_length, want.length);
			if (last_of_frame !== want.last)
				report("last_of_frame", last_of_frame, want.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_shadow.start_byte = START_BYTE_RST;
			regs_shadow.end_byte = END_BYTE_RST;
			regs_shadow.max_frame_len = MAX_LEN_RST;
			head = 0;
			held = 0;
			due_beats.delete();
			due_count = 0;
		end else begin
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					CFG_START_BYTE: regs_shadow.start_byte = cfg_data;
					CFG_END_BYTE: regs_shadow.end_byte = cfg_data;
					CFG_MAX_LEN: regs_shadow.max_frame_len = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (frame_valid === 1'b1 && frame_ready === 1'b1)
				check_beat();
			if (rx_valid === 1'b1 && rx_ready === 1'b1)
				hunt_byte(rx_byte);
			due_count = due_beats.size();
		end
	end

endmodule

// ===== bench/sof_len_eof_frame_hunter_unit_tb.sv =====
// Frame hunter testbench top: clock, reset, register writes, byte stimulus and verdict.
module sof_len_eof_frame_hunter_unit_tb;
	import sofh_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 22;
	localparam int SETTLE_CYCLES = 450;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int unsigned NEST_TOTAL = 24;
	localparam int unsigned SHORT_MAX = 15;
	localparam longint WATCHDOG_TIME = 1500000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatch_count;
	int                    bytes_due;

	logic [DATA_W-1:0] plan [$];
	logic [DATA_W-1:0] cur_start;
	logic [DATA_W-1:0] cur_end;
	int unsigned       gen_cap;
	int                burst_left = 0;
	int                hold_asks = 0;

	sofh_rx_if    rx_ch ();
	sofh_frame_if frame_ch ();

	sof_len_eof_frame_hunter_unit #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.frame(frame_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sofh_frame_checker #(
		.RING_DEPTH(RING_DEPTH)
	) frame_watch (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_ch.valid),
		.rx_ready(rx_ch.ready),
		.rx_byte(rx_ch.rx_byte),
		.frame_valid(frame_ch.valid),
		.frame_ready(frame_ch.ready),
		.frame_byte(frame_ch.frame_byte),
		.frame_length(frame_ch.frame_length),
		.last_of_frame(frame_ch.last_of_frame),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.bytes_due(bytes_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_TIME);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: rotating stall pattern, plus one long hold-off when asked.
	initial begin : frame_sink
		int unsigned tick;
		int          hold_served;
		tick = 0;
		hold_served = 0;
		frame_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_served != hold_asks) begin
				hold_served++;
				frame_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else begin
				case ((tick / 40) % 4)
					0: frame_ch.ready <= 1'b1;
					1: frame_ch.ready <= 1'($urandom_range(0, 1));
					2: frame_ch.ready <= ($urandom_range(0, 3) == 0);
					default: frame_ch.ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender side: bursts of random length separated by random gaps.
	task automatic send_byte(input logic [DATA_W-1:0] b);
		int gap;
		@(negedge clk);
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		burst_left--;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
	endtask

	task automatic send_plan();
		foreach (plan[i])
			send_byte(plan[i]);
		plan.delete();
	endtask

	task automatic settle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (bytes_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Builds the first keep bytes of a frame of the given total length.
	task automatic append_frame(input int unsigned total, input int unsigned keep,
			input bit good_end);
		logic [15:0]       len;
		logic [DATA_W-1:0] b;
		int unsigned       k;
		len = 16'(total - FRAME_OVERHEAD);
		for (k = 0; k < keep; k++) begin
			if (k == 0)
				b = cur_start;
			else if (k == LEN_LO_OFF)
				b = len[7:0];
			else if (k == LEN_HI_OFF)
				b = len[15:8];
			else if (k == total - 1)
				b = good_end ? cur_end : cur_end ^ 8'($urandom_range(1, 255));
			else
				b = 8'($urandom);
			plan.push_back(b);
		end
	endtask

	function automatic int unsigned pick_total();
		int unsigned top;
		top = (gen_cap < SHORT_MAX) ? gen_cap : SHORT_MAX;
		if ($urandom_range(0, 15) == 0)
			return gen_cap;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(FRAME_OVERHEAD, gen_cap);
		return $urandom_range(FRAME_OVERHEAD, top);
	endfunction

	task automatic add_sequence();
		int unsigned pick;
		int unsigned total;
		int unsigned k;
		pick = $urandom_range(0, 99);
		total = pick_total();
		if (pick < 55) begin
			append_frame(total, total, 1'b1);
		end else if (pick < 65) begin
			repeat ($urandom_range(1, 6)) plan.push_back(8'($urandom));
		end else if (pick < 75) begin
			append_frame(total, total, 1'b0);
		end else if (pick < 83) begin
			// length field pointing past the limit, sometimes by exactly one
			if ($urandom_range(0, 1) == 0)
				total = gen_cap + 1;
			else
				total = $urandom_range(gen_cap + 1, 16'hFFFF + FRAME_OVERHEAD);
			append_frame(total, HDR_BYTES, 1'b1);
		end else if (pick < 91) begin
			append_frame(total, $urandom_range(HDR_BYTES, total - 1), 1'b1);
		end else if (gen_cap >= NEST_TOTAL) begin
			// open header that swallows two whole frames, then closes badly:
			// resync then finds both, and the second waits for the next byte
			append_frame(NEST_TOTAL, HDR_BYTES, 1'b1);
			append_frame(FRAME_OVERHEAD, FRAME_OVERHEAD, 1'b1);
			append_frame(FRAME_OVERHEAD, FRAME_OVERHEAD, 1'b1);
			for (k = HDR_BYTES + 2 * FRAME_OVERHEAD; k < NEST_TOTAL - 1; k++)
				plan.push_back(8'($urandom));
			plan.push_back(cur_end ^ 8'($urandom_range(1, 255)));
		end else begin
			append_frame(total, total, 1'b1);
		end
	endtask

	task automatic apply_setting(input int p);
		logic [CFG_DATA_W-1:0] s;
		logic [CFG_DATA_W-1:0] e;
		logic [CFG_DATA_W-1:0] m;
		int unsigned           cap;
		case (p)
			1: begin s = 8'hA5; e = 8'h5A; m = 8'd64; end
			2: begin s = 8'h00; e = 8'hFF; m = 8'd9; end
			3: begin s = 8'hFF; e = 8'h00; m = 8'hFF; end
			4: begin s = 8'h7E; e = 8'h7E; m = 8'd5; end
			5: begin s = 8'hC3; e = 8'h3C; m = 8'd32; end
			default: begin
				s = 8'($urandom);
				e = 8'($urandom);
				m = 8'($urandom_range(9, 64));
			end
		endcase
		write_reg(CFG_START_BYTE, s);
		write_reg(CFG_END_BYTE, e);
		write_reg(CFG_MAX_LEN, m);
		end_writes();
		cur_start = s;
		cur_end = e;
		cap = (m[LEN_W-1:0] > RING_DEPTH) ? RING_DEPTH : m[LEN_W-1:0];
		// below nine nothing passes; still build normal-looking frames
		gen_cap = (cap < FRAME_OVERHEAD) ? FRAME_OVERHEAD : cap;
	endtask

	initial begin : stimulus
		int p;
		int phase_bytes;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_BYTE;
		cfg_data = '0;
		arst_n = 1'b0;
		cur_start = START_BYTE_RST;
		cur_end = END_BYTE_RST;
		gen_cap = MAX_LEN_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// unused index must leave every register alone
		write_reg(CFG_SPARE, 8'h5A);
		end_writes();

		// reset settings: start 00, end FF, limit 64
		plan = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		plan.push_back(8'h00); plan.push_back(8'hAA);
		plan.push_back(8'hFF); plan.push_back(8'hFF);
		plan.push_back(8'h00); plan.push_back(8'hAA);
		plan.push_back(8'h38); plan.push_back(8'h00);
		plan.push_back(8'h00); plan.push_back(8'h11);
		plan.push_back(8'h00); plan.push_back(8'h00);
		plan.push_back(8'h22); plan.push_back(8'h33);
		plan.push_back(8'h44); plan.push_back(8'h55);
		plan.push_back(8'hFE);
		send_plan();

		for (p = 1; p < PHASES; p++) begin
			settle();
			apply_setting(p);
			if (p == 1) begin
				hold_asks++;
				// a good frame up front so the held-off output backs up the input
				append_frame(FRAME_OVERHEAD, FRAME_OVERHEAD, 1'b1);
			end
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				add_sequence();
				phase_bytes += plan.size();
				send_plan();
			end
		end
		settle();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
